// ===== rtl/wls_pkg.sv =====
// ----------------------------------------------------------------------------
// wls_pkg: shared types and constants
// Tap-vote beat format, register indexes and field widths for the
// write-leveling window search.
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int SPT_W  = 8;   // samples per tap
  localparam int TAP_W  = 6;   // tap index and tap count
  localparam int DLY_W  = 5;   // reported delay and window length
  localparam int LEN_W  = 7;   // signed run length, -1 means no run
  localparam int CIDX_W = 2;   // config register index
  localparam int CDAT_W = 8;   // config write data

  // Config register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_SAMPLES_PER_TAP = 2'd0,
    CFG_TAPS_TO_SCAN    = 2'd1,
    CFG_FORCED_DELAY    = 2'd2
  } cfg_reg_e;

  // Reset values of the config registers
  localparam logic [SPT_W-1:0] SPT_RESET    = 8'd128;
  localparam logic [TAP_W-1:0] TAPS_RESET   = 6'd32;
  localparam logic [TAP_W-1:0] FORCED_RESET = 6'h3F;

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [SPT_W-1:0] spt;      // samples per tap, never zero
    logic [TAP_W-1:0] taps;     // clamped tap count, never zero
    logic [TAP_W-1:0] forced;   // signed forced delay, negative = search
  } cfg_t;

  // One voted tap, front to back
  typedef struct packed {
    logic             vote;     // majority vote of the tap
    logic [TAP_W-1:0] idx;      // tap number, zero opens a new scan
    logic             last;     // final tap of the scan
  } tap_beat_t;

endpackage

// ===== rtl/wls_in_if.sv =====
// ----------------------------------------------------------------------------
// wls_in_if: strobe sample channel
// Valid/ready channel carrying one strobe sample and the scan start flag.
// ----------------------------------------------------------------------------
interface wls_in_if;
  logic valid;
  logic ready;
  logic sample_one;
  logic start_scan;

  modport source (output valid, output sample_one, output start_scan, input ready);
  modport sink   (input valid, input sample_one, input start_scan, output ready);
endinterface

// ===== rtl/wls_out_if.sv =====
// ----------------------------------------------------------------------------
// wls_out_if: scan result channel
// Valid/ready channel carrying the chosen delay of one lane scan.
// ----------------------------------------------------------------------------
interface wls_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] chosen_delay;
  logic       found;
  logic [4:0] window_length;

  modport source (output valid, output chosen_delay, output found,
                  output window_length, input ready);
  modport sink   (input valid, input chosen_delay, input found,
                  input window_length, output ready);
endinterface

// ===== rtl/wls_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wls_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wls_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wls_front.sv =====
// ----------------------------------------------------------------------------
// wls_front: sample counting and tap vote
// Takes strobe samples, counts samples and ones per tap, and pushes one
// voted tap beat into the queue when a tap completes.
// ----------------------------------------------------------------------------
module wls_front (
  input  logic                clk,
  input  logic                rst_n,
  input  wls_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                sample_one,
  input  logic                start_scan,
  input  logic                q_full,
  output logic                q_push,
  output wls_pkg::tap_beat_t  q_beat
);

  logic [wls_pkg::SPT_W-1:0] smp_cnt_r, smp_cnt_nxt;
  logic [wls_pkg::SPT_W-1:0] one_cnt_r, one_cnt_nxt;
  logic [wls_pkg::TAP_W-1:0] tap_idx_r, tap_idx_nxt;

  logic                      accept;
  logic [wls_pkg::SPT_W-1:0] smp_cur, one_cur, smp_inc, one_inc;
  logic [wls_pkg::TAP_W-1:0] tap_cur;
  logic                      scan_done, tap_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Count the beat, vote when the tap is complete
  always_comb begin
    smp_cur   = start_scan ? '0 : smp_cnt_r;
    one_cur   = start_scan ? '0 : one_cnt_r;
    tap_cur   = start_scan ? '0 : tap_idx_r;
    scan_done = (tap_cur >= cfg.taps);
    smp_inc   = smp_cur + 8'd1;
    one_inc   = one_cur + {7'd0, sample_one};
    tap_end   = (smp_inc >= cfg.spt);

    smp_cnt_nxt = smp_cnt_r;
    one_cnt_nxt = one_cnt_r;
    tap_idx_nxt = tap_idx_r;
    if (accept) begin
      if (scan_done) begin
        smp_cnt_nxt = smp_cur;
        one_cnt_nxt = one_cur;
        tap_idx_nxt = tap_cur;
      end else if (tap_end) begin
        smp_cnt_nxt = '0;
        one_cnt_nxt = '0;
        tap_idx_nxt = tap_cur + 6'd1;
      end else begin
        smp_cnt_nxt = smp_inc;
        one_cnt_nxt = one_inc;
        tap_idx_nxt = tap_cur;
      end
    end

    // tie counts as zero
    q_push      = accept && !scan_done && tap_end;
    q_beat.vote = ({one_inc, 1'b0} > {1'b0, cfg.spt});
    q_beat.idx  = tap_cur;
    q_beat.last = ((tap_cur + 6'd1) == cfg.taps);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_cnt_r <= '0;
      one_cnt_r <= '0;
      tap_idx_r <= '0;
    end else begin
      smp_cnt_r <= smp_cnt_nxt;
      one_cnt_r <= one_cnt_nxt;
      tap_idx_r <= tap_idx_nxt;
    end
  end

endmodule

// ===== rtl/wls_tap_fifo.sv =====
// ----------------------------------------------------------------------------
// wls_tap_fifo: two-entry tap beat queue
// Decouples the sample front from the window tracker.
// ----------------------------------------------------------------------------
module wls_tap_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wls_pkg::tap_beat_t  push_beat,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output wls_pkg::tap_beat_t  head
);

  wls_pkg::tap_beat_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/wls_back.sv =====
// ----------------------------------------------------------------------------
// wls_back: window tracker and result register
// Tracks runs of voted ones, keeps the longest, and registers one result
// after the last tap of a scan.
// ----------------------------------------------------------------------------
module wls_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wls_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  wls_pkg::tap_beat_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          chosen_delay,
  output logic                found,
  output logic [4:0]          window_length
);

  localparam logic signed [wls_pkg::LEN_W-1:0] NO_RUN = -7'sd1;

  logic                                open_r, open_nxt;
  logic [wls_pkg::TAP_W-1:0]           wstart_r, wstart_nxt;
  logic [wls_pkg::TAP_W-1:0]           bstart_r, bstart_nxt;
  logic signed [wls_pkg::LEN_W-1:0]    blen_r, blen_nxt;
  logic                                oval_r, oval_nxt;
  logic [wls_pkg::DLY_W-1:0]           odly_r, odly_nxt;
  logic                                ofound_r, ofound_nxt;
  logic [wls_pkg::DLY_W-1:0]           olen_r, olen_nxt;

  logic                                open_c;
  logic [wls_pkg::TAP_W-1:0]           wstart_c, bstart_c;
  logic signed [wls_pkg::LEN_W-1:0]    blen_c, run_len;
  logic                                slot_free;

  assign slot_free = !oval_r || out_ready;
  assign q_pop     = !q_empty && (!q_head.last || slot_free);

  // Run tracking for the popped tap, tap zero starts from a clean scan
  always_comb begin
    open_c   = (q_head.idx == '0) ? 1'b0 : open_r;
    wstart_c = (q_head.idx == '0) ? '0 : wstart_r;
    bstart_c = (q_head.idx == '0) ? '0 : bstart_r;
    blen_c   = (q_head.idx == '0) ? NO_RUN : blen_r;
    run_len  = $signed({1'b0, q_head.idx}) - $signed({1'b0, wstart_c});

    open_nxt   = open_r;
    wstart_nxt = wstart_r;
    bstart_nxt = bstart_r;
    blen_nxt   = blen_r;
    if (q_pop) begin
      open_nxt   = open_c;
      wstart_nxt = wstart_c;
      bstart_nxt = bstart_c;
      blen_nxt   = blen_c;
      if (open_c) begin
        if (!q_head.vote || q_head.last) begin
          open_nxt = 1'b0;
          if (run_len > blen_c) begin
            bstart_nxt = wstart_c;
            blen_nxt   = run_len;
          end
        end
      end else if (q_head.vote) begin
        open_nxt   = 1'b1;
        wstart_nxt = q_head.idx;
      end
    end
  end

  // Result register, loaded on the last tap
  always_comb begin
    oval_nxt   = oval_r && !out_ready;
    odly_nxt   = odly_r;
    ofound_nxt = ofound_r;
    olen_nxt   = olen_r;
    if (q_pop && q_head.last) begin
      oval_nxt = 1'b1;
      if (!cfg.forced[wls_pkg::TAP_W-1]) begin
        odly_nxt   = cfg.forced[wls_pkg::DLY_W-1:0];
        ofound_nxt = 1'b1;
      end else if (blen_nxt > 7'sd0 && bstart_nxt != '0) begin
        odly_nxt   = bstart_nxt[wls_pkg::DLY_W-1:0];
        ofound_nxt = 1'b1;
      end else begin
        odly_nxt   = '0;
        ofound_nxt = 1'b0;
      end
      olen_nxt = (blen_nxt > 7'sd0) ? blen_nxt[wls_pkg::DLY_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      wstart_r <= '0;
      bstart_r <= '0;
      blen_r   <= NO_RUN;
      oval_r   <= 1'b0;
    end else begin
      open_r   <= open_nxt;
      wstart_r <= wstart_nxt;
      bstart_r <= bstart_nxt;
      blen_r   <= blen_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odly_r   <= odly_nxt;
    ofound_r <= ofound_nxt;
    olen_r   <= olen_nxt;
  end

  assign out_valid     = oval_r;
  assign chosen_delay  = odly_r;
  assign found         = ofound_r;
  assign window_length = olen_r;

endmodule

// ===== rtl/write_leveling_window_search.sv =====
// ----------------------------------------------------------------------------
// write_leveling_window_search: write-leveling delay search for one lane
// Majority-votes strobe samples per delay tap and picks the start of the
// longest window of ones, or the forced delay.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one strobe sample per beat; start_scan on the first sample of
//            a lane scan clears all scan state before that sample counts.
//   out_ch : one result beat after the last sample of the last tap.
//   cfg_ch : register writes, always ready; write only while the block is
//            idle. Index 0 samples per tap, 1 taps to scan, 2 forced delay.
// Throughput: one sample per cycle while the queue is not full. The sample
//   front feeds voted taps into a two-entry queue, and the window tracker drains
//   one tap per cycle unless a result still waits on out_ch. Result path: the
//   front votes the last sample into the queue, then the tracker's result register.
// Stall: while a result waits on out_ch, the tracker holds the next scan's
//   last tap; earlier taps still drain, and in_ch stalls only once the queue
//   is full.
// Reset: registers return to 128 samples, 32 taps, search mode; scan state
//   is cleared, so a scan may start without start_scan.
// ----------------------------------------------------------------------------
module write_leveling_window_search #(
  parameter int MAX_TAPS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  wls_in_if.sink   in_ch,
  wls_out_if.source out_ch,
  wls_cfg_if.sink  cfg_ch
);

  // Tap counts above this are clamped
  localparam int                          TAP_CAP   = (MAX_TAPS < 63) ? MAX_TAPS : 63;
  localparam logic [wls_pkg::TAP_W-1:0]   TAP_CAP_V = wls_pkg::TAP_W'(TAP_CAP);

  logic [wls_pkg::SPT_W-1:0] spt_r, spt_nxt;
  logic [wls_pkg::TAP_W-1:0] taps_r, taps_nxt;
  logic [wls_pkg::TAP_W-1:0] forced_r, forced_nxt;

  wls_pkg::cfg_t      cfg;
  wls_pkg::tap_beat_t push_beat, head;
  logic               push, pop, full, empty;

  assign cfg_ch.ready = 1'b1;

  // Config register writes
  always_comb begin
    spt_nxt    = spt_r;
    taps_nxt   = taps_r;
    forced_nxt = forced_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (wls_pkg::cfg_reg_e'(cfg_ch.index))
        wls_pkg::CFG_SAMPLES_PER_TAP: spt_nxt    = cfg_ch.data;
        wls_pkg::CFG_TAPS_TO_SCAN:    taps_nxt   = cfg_ch.data[wls_pkg::TAP_W-1:0];
        wls_pkg::CFG_FORCED_DELAY:    forced_nxt = cfg_ch.data[wls_pkg::TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r    <= wls_pkg::SPT_RESET;
      taps_r   <= wls_pkg::TAPS_RESET;
      forced_r <= wls_pkg::FORCED_RESET;
    end else begin
      spt_r    <= spt_nxt;
      taps_r   <= taps_nxt;
      forced_r <= forced_nxt;
    end
  end

  // Effective settings: zero samples or zero taps count as one, taps clamped
  always_comb begin
    cfg.spt = (spt_r == '0) ? 8'd1 : spt_r;
    if (taps_r == '0) begin
      cfg.taps = 6'd1;
    end else if (taps_r > TAP_CAP_V) begin
      cfg.taps = TAP_CAP_V;
    end else begin
      cfg.taps = taps_r;
    end
    cfg.forced = forced_r;
  end

  wls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .sample_one (in_ch.sample_one),
    .start_scan (in_ch.start_scan),
    .q_full     (full),
    .q_push     (push),
    .q_beat     (push_beat)
  );

  wls_tap_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  wls_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (empty),
    .q_head        (head),
    .q_pop         (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .chosen_delay  (out_ch.chosen_delay),
    .found         (out_ch.found),
    .window_length (out_ch.window_length)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: write-leveling window search testbench
// Streams strobe samples into the lane search and checks each scan result
// against a cycle-free predictor of the tap votes and window tracking.
// Directed scans cover ties, clamped settings, forced delays and mid-scan
// tap changes. Random scans with random idles on both channels follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TB_MAX_TAPS = 32;
  localparam int SETTLE      = 8;   // cycles waited after the lane goes quiet

  typedef struct packed {
    logic sample_one;
    logic start_scan;
  } strobe_t;

  typedef struct packed {
    logic [wls_pkg::DLY_W-1:0] chosen_delay;
    logic                      found;
    logic [wls_pkg::DLY_W-1:0] window_length;
  } lane_result_t;

  logic clk;
  logic rst_n;

  wls_in_if  in_ch();
  wls_out_if out_ch();
  wls_cfg_if cfg_ch();

  write_leveling_window_search #(.MAX_TAPS(TB_MAX_TAPS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Register mirror
  logic [wls_pkg::SPT_W-1:0] spt_reg;
  logic [wls_pkg::TAP_W-1:0] taps_reg;
  logic [wls_pkg::TAP_W-1:0] forced_reg;

  // Scan state mirror
  logic [7:0]                       sample_cnt;
  logic [7:0]                       ones_cnt;
  logic [wls_pkg::TAP_W-1:0]        tap_idx;
  logic                             win_open;
  logic [wls_pkg::DLY_W-1:0]        win_start;
  logic [wls_pkg::DLY_W-1:0]        best_start;
  logic signed [wls_pkg::LEN_W-1:0] best_len;

  strobe_t      sample_q[$];
  lane_result_t expected_windows[$];

  int in_idle_pct;
  int out_idle_pct;
  int err_count;
  int samples_taken;
  int results_seen;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 50) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int unsigned taps_in_use();
    if (taps_reg == '0) return 1;
    if (taps_reg > TB_MAX_TAPS) return TB_MAX_TAPS;
    return taps_reg;
  endfunction

  function automatic void clear_scan();
    sample_cnt = '0;
    ones_cnt   = '0;
    tap_idx    = '0;
    win_open   = 1'b0;
    win_start  = '0;
    best_start = '0;
    best_len   = -1;
  endfunction

  // Predict the effect of one accepted strobe sample
  function automatic void track_sample(input logic smp, input logic opens);
    int unsigned  taps;
    int unsigned  spt;
    logic         vote;
    int           run_len;
    lane_result_t res;
    if (opens) clear_scan();
    taps = taps_in_use();
    if (tap_idx >= taps) return;          // scan done, sample dropped
    spt = (spt_reg == '0) ? 1 : spt_reg;
    sample_cnt = sample_cnt + 1'b1;
    ones_cnt   = ones_cnt + smp;
    if (sample_cnt < spt) return;

    // majority vote, a tie is a zero
    vote       = (2 * ones_cnt > spt);
    sample_cnt = '0;
    ones_cnt   = '0;

    // window tracking; closing tap is a zero or the last tap
    if (win_open) begin
      if (!vote || tap_idx == taps - 1) begin
        win_open = 1'b0;
        run_len  = int'(tap_idx) - int'(win_start);
        if (run_len > best_len) begin
          best_start = win_start;
          best_len   = wls_pkg::LEN_W'(run_len);
        end
      end
    end else if (vote) begin
      win_open  = 1'b1;
      win_start = tap_idx[wls_pkg::DLY_W-1:0];
    end
    tap_idx = tap_idx + 1'b1;
    if (tap_idx < taps) return;

    res.window_length = (best_len > 0) ? best_len[wls_pkg::DLY_W-1:0] : '0;
    if (!forced_reg[wls_pkg::TAP_W-1]) begin
      res.chosen_delay = forced_reg[wls_pkg::DLY_W-1:0];
      res.found        = 1'b1;
    end else if (best_len > 0 && best_start != '0) begin
      res.chosen_delay = best_start;
      res.found        = 1'b1;
    end else begin
      res.chosen_delay = '0;
      res.found        = 1'b0;
    end
    expected_windows.push_back(res);
  endfunction

  // Sample driver
  always @(posedge clk) begin : strobe_drv
    strobe_t nxt;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.sample_one <= 1'b0;
      in_ch.start_scan <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_sample(in_ch.sample_one, in_ch.start_scan);
        samples_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = sample_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.sample_one <= nxt.sample_one;
          in_ch.start_scan <= nxt.start_scan;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    lane_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_windows.size() == 0) begin
          report_mismatch("result beat with no scan result pending");
        end else begin
          want = expected_windows.pop_front();
          if (out_ch.chosen_delay !== want.chosen_delay)
            report_mismatch($sformatf("chosen_delay %0d, want %0d",
                                      out_ch.chosen_delay, want.chosen_delay));
          if (out_ch.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", out_ch.found, want.found));
          if (out_ch.window_length !== want.window_length)
            report_mismatch($sformatf("window_length %0d, want %0d",
                                      out_ch.window_length, want.window_length));
        end
      end
    end
  end

  // Register write, mirror updated on the handshake
  task automatic write_reg(input wls_pkg::cfg_reg_e idx,
                           input logic [wls_pkg::CDAT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      wls_pkg::CFG_SAMPLES_PER_TAP: spt_reg = val;
      wls_pkg::CFG_TAPS_TO_SCAN:    taps_reg = val[wls_pkg::TAP_W-1:0];
      wls_pkg::CFG_FORCED_DELAY:    forced_reg = val[wls_pkg::TAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int spt, input int taps, input int forced);
    write_reg(wls_pkg::CFG_SAMPLES_PER_TAP, wls_pkg::CDAT_W'(spt));
    write_reg(wls_pkg::CFG_TAPS_TO_SCAN, wls_pkg::CDAT_W'(taps));
    write_reg(wls_pkg::CFG_FORCED_DELAY, wls_pkg::CDAT_W'(forced));
    @(negedge clk);
  endtask

  // Hold off until the lane is quiet: queue empty, no beat up, nothing owed
  task automatic drain();
    while (sample_q.size() != 0 || in_ch.valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void push_item(input logic smp, input logic opens);
    sample_q.push_back(strobe_t'{sample_one: smp, start_scan: opens});
  endfunction

  // One scan of runs of ones; cut > 0 stops it early after cut samples
  task automatic queue_scan(input int spt, input int taps, input int cut);
    int   total;
    int   n;
    int   flip_pct;
    int   bias;
    logic level;
    total = spt * taps;
    if (cut > 0 && cut < total) total = cut;
    n        = 0;
    level    = 1'($urandom_range(1));
    bias     = $urandom_range(55, 100);
    case ($urandom_range(3))
      0:       flip_pct = 0;
      1:       flip_pct = 10;
      2:       flip_pct = 30;
      default: flip_pct = 60;
    endcase
    for (int t = 0; t < taps && n < total; t++) begin
      if ($urandom_range(99) < flip_pct) level = ~level;
      for (int s = 0; s < spt && n < total; s++) begin
        push_item($urandom_range(99) < (level ? bias : 100 - bias), n == 0);
        n++;
      end
    end
  endtask

  // Random settings, then a batch of scans, then wait for every result
  task automatic random_phase(output int queued);
    int spt;
    int taps;
    int forced;
    int spt_eff;
    int taps_eff;
    int budget;
    int kind;
    int total;
    case ($urandom_range(9))
      0:       taps = 0;
      1:       taps = TB_MAX_TAPS;
      2:       taps = $urandom_range(33, 63);
      default: taps = $urandom_range(1, 12);
    endcase
    taps_eff = (taps == 0) ? 1 : ((taps > TB_MAX_TAPS) ? TB_MAX_TAPS : taps);
    case ($urandom_range(9))
      0:       spt = 0;
      1:       spt = $urandom_range(5, 9);
      default: spt = $urandom_range(1, 4);
    endcase
    if (taps_eff >= 16) spt = $urandom_range(1, 2);
    spt_eff = (spt == 0) ? 1 : spt;
    case ($urandom_range(9))
      7:       forced = -2 - int'($urandom_range(30));
      8:       forced = $urandom_range(1) ? 31 : 0;
      9:       forced = $urandom_range(31);
      default: forced = -1;
    endcase
    set_config(spt, taps, forced);

    queued = 0;
    budget = $urandom_range(60, 160);
    total  = spt_eff * taps_eff;
    while (queued < budget) begin
      kind = $urandom_range(99);
      if (kind < 80 || total < 2) begin
        queue_scan(spt_eff, taps_eff, 0);
        queued += total;
      end else if (kind < 90) begin
        // aborted scan, the next start_scan restarts it
        queue_scan(spt_eff, taps_eff, $urandom_range(1, total - 1));
        queued += total / 2;
      end else begin
        // stray samples after a finished scan are dropped
        queue_scan(spt_eff, taps_eff, 0);
        queued += total;
        repeat ($urandom_range(1, 4)) push_item(1'($urandom_range(1)), 1'b0);
      end
    end
    drain();
  endtask

  // Stimulus
  initial begin : stimulus
    int queued;
    int mode_items;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample_one = 1'b0;
    in_ch.start_scan = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = wls_pkg::CFG_SAMPLES_PER_TAP;
    cfg_ch.data      = '0;
    spt_reg          = wls_pkg::SPT_RESET;
    taps_reg         = wls_pkg::TAPS_RESET;
    forced_reg       = wls_pkg::FORCED_RESET;
    err_count        = 0;
    samples_taken    = 0;
    results_seen     = 0;
    in_idle_pct      = 20;
    out_idle_pct     = 74;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // First scan with no start_scan, then a start at tap 0 and a tie of runs
    set_config(1, 4, -1);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b1);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b0);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    drain();

    // Zero samples and zero taps clamp to one; forced delay wins
    set_config(0, 0, 5);
    push_item(1'b1, 1'b1);
    drain();

    // Two samples per tap: a tie votes zero, run opens on the last tap
    set_config(2, 2, -32);
    push_item(1'b1, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    drain();

    // Tap count lowered below the current tap in the middle of a scan
    set_config(1, 8, -1);
    push_item(1'b1, 1'b1);
    repeat (4) push_item(1'b1, 1'b0);
    drain();
    write_reg(wls_pkg::CFG_TAPS_TO_SCAN, wls_pkg::CDAT_W'(3));
    @(negedge clk);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b0);
    push_item(1'b1, 1'b0);
    drain();

    // Largest settings, a few scans only
    set_config(255, 2, 31);
    queue_scan(255, 2, 0);
    drain();
    set_config(1, TB_MAX_TAPS, -1);
    repeat (3) queue_scan(1, TB_MAX_TAPS, 0);
    drain();
    set_config(3, 63, 0);
    queue_scan(3, TB_MAX_TAPS, 0);
    drain();

    // Random scans under three idle patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 20;
          out_idle_pct = 74;
        end
        1: begin
          in_idle_pct  = 74;
          out_idle_pct = 20;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      mode_items = 0;
      while (mode_items < 180) begin
        random_phase(queued);
        mode_items += queued;
      end
    end
    drain();

    $display("tb_top: %0d strobe samples taken, %0d scan results checked, %0d mismatches",
             samples_taken, results_seen, err_count);
    $display("tb_top: forced and searched delays, clamped settings, aborted scans, dropped samples");
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
